/* src/fism_pkg.sv */
// Shared types and constants for the frame interval statistics monitor.
package fism_pkg;

  localparam logic [1:0] OP_PRESENT = 2'd0;
  localparam logic [1:0] OP_POLL    = 2'd1;
  localparam logic [1:0] OP_DRESET  = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [0:0] REG_FREQ     = 1'b0;
  localparam logic [0:0] REG_INTERVAL = 1'b1;

  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam logic [30:0] MAX31 = {31{1'b1}};
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [29:0] MHZ_SCALE = 30'd1000000000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [62:0] counter_tick;
    logic [31:0] ms_now;
    logic        present_failed;
  } in_item_t;

  typedef struct packed {
    logic [30:0] present_count;
    logic [30:0] failure_count;
    logic [30:0] interval_count;
    logic [62:0] interval_mean_us;
    logic [62:0] interval_peak_us;
    logic [29:0] rate_millihertz;
    logic [30:0] latency_samples;
    logic [62:0] latency_avg_us;
    logic [62:0] latency_max_us;
  } out_item_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture item, apply poll / display reset
    CMD_DIV_FRAME, // start tick-to-us conversion of frame delta
    CMD_ACC_FRAME,
    CMD_DIV_LAT,
    CMD_ACC_LAT,
    CMD_TALLY,     // count presents, test report interval
    CMD_DIV_FAVG,
    CMD_DIV_LAVG,
    CMD_DIV_RATE,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic is_present;
    logic frame_ok;
    logic lat_ok;
    logic report_due;
    logic div_busy;
  } status_t;

endpackage

/* src/fism_if.sv */
// Valid/ready channel interface.
interface fism_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/fism_div.sv */
// Restoring 64-bit divider, one quotient bit per cycle.
module fism_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);
  logic [6:0]  count;
  logic [63:0] dvs;
  logic [64:0] trial;

  assign trial = {remainder, quotient[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 7'd64;
      quotient <= dividend;
      remainder <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial[64]) begin
        remainder <= {remainder[62:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end else begin
        remainder <= trial[63:0];
        quotient <= {quotient[62:0], 1'b1};
      end
      count <= count - 7'd1;
      if (count == 7'd1) busy <= 1'b0;
    end
  end
endmodule

/* src/fism_dp.sv */
// Datapath: event state, accumulators, shared divider and result register.
module fism_dp (
  input  logic               clk,
  input  logic               rst,
  input  fism_pkg::cmd_t     cmd,
  input  fism_pkg::in_item_t in_item,
  input  fism_pkg::cfg_item_t cfg,
  input  logic               cfg_we,
  output fism_pkg::status_t  status,
  output fism_pkg::out_item_t result
);
  logic [31:0] freq, interval;
  logic [62:0] prev_tick, poll_tick, rep_poll_tick;
  logic [62:0] frame_sum, frame_peak, lat_sum, lat_peak;
  logic [30:0] frame_tally, present_tally, failure_tally, lat_tally;
  logic [31:0] last_ms;
  fism_pkg::in_item_t item;
  logic [62:0] delta, us;
  logic [62:0] lat_delta;
  logic        frame_ok, lat_ok, due;
  logic [62:0] favg;

  logic        div_start, div_busy;
  logic [63:0] div_a, div_b, div_q, div_r;

  // us conversion stages: divider gives whole and remainder; frac via second pass
  logic        conv_phase;
  logic [62:0] whole;
  logic [83:0] frac_num;
  logic [83:0] whole_us;
  logic [63:0] sum_us;

  fism_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  assign lat_delta = item.counter_tick - poll_tick;
  assign frac_num = 84'(div_r[31:0]) * 84'(fism_pkg::US_PER_S);
  assign whole_us = {21'd0, whole} * 84'(fism_pkg::US_PER_S);
  assign sum_us = whole_us[63:0] + {44'd0, div_q[19:0]};

  always_comb begin
    us = sum_us[63] || (whole_us[83:63] != '0) ? fism_pkg::MAX63 : sum_us[62:0];
    if (freq == '0 || delta == '0) us = '0;
  end

  function automatic logic [62:0] sat_add(logic [62:0] a, logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? fism_pkg::MAX63 : s[62:0];
  endfunction

  function automatic logic [30:0] sat_inc(logic [30:0] v);
    return v == fism_pkg::MAX31 ? v : v + 31'd1;
  endfunction

  assign status.is_present = item.opcode == fism_pkg::OP_PRESENT;
  assign status.frame_ok = frame_ok;
  assign status.lat_ok = lat_ok;
  assign status.report_due = due;
  assign status.div_busy = div_busy || div_start;

  always_comb begin
    div_start = 1'b0;
    div_a = {1'b0, delta};
    div_b = {32'd0, freq};
    unique case (cmd)
      fism_pkg::CMD_DIV_FRAME: div_start = freq != '0;
      fism_pkg::CMD_DIV_LAT: begin
        div_start = freq != '0;
        div_a = {1'b0, lat_delta};
      end
      fism_pkg::CMD_DIV_FAVG: begin
        div_start = frame_tally != '0;
        div_a = {1'b0, frame_sum};
        div_b = {33'd0, frame_tally};
      end
      fism_pkg::CMD_DIV_LAVG: begin
        div_start = lat_tally != '0;
        div_a = {1'b0, lat_sum};
        div_b = {33'd0, lat_tally};
      end
      fism_pkg::CMD_DIV_RATE: begin
        div_start = favg != '0;
        div_a = {34'd0, fism_pkg::MHZ_SCALE};
        div_b = {1'b0, favg};
      end
      default: ;
    endcase
    if (conv_phase && !div_busy) begin
      div_start = 1'b1;
      div_a = frac_num[63:0];
      div_b = {32'd0, freq};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= 32'd10000000;
      interval <= 32'd5000;
      prev_tick <= '0; poll_tick <= '0; rep_poll_tick <= '0; last_ms <= '0;
      frame_sum <= '0; frame_peak <= '0; lat_sum <= '0; lat_peak <= '0;
      frame_tally <= '0; present_tally <= '0; failure_tally <= '0; lat_tally <= '0;
      conv_phase <= 1'b0;
      frame_ok <= 1'b0; lat_ok <= 1'b0; due <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg.index == fism_pkg::REG_FREQ) freq <= cfg.data;
        else interval <= cfg.data;
      end
      if (conv_phase && !div_busy) conv_phase <= 1'b0;
      unique case (cmd)
        fism_pkg::CMD_LOAD: begin
          item <= in_item;
          frame_ok <= prev_tick != '0;
          lat_ok <= poll_tick != '0 && poll_tick != rep_poll_tick
                    && in_item.counter_tick >= poll_tick;
          if (in_item.opcode == fism_pkg::OP_POLL) poll_tick <= in_item.counter_tick;
          if (in_item.opcode == fism_pkg::OP_DRESET) prev_tick <= '0;
          if (in_item.opcode == fism_pkg::OP_PRESENT) begin
            prev_tick <= in_item.counter_tick;
            delta <= in_item.counter_tick > prev_tick ?
                     in_item.counter_tick - prev_tick : '0;
          end
        end
        fism_pkg::CMD_DIV_FRAME: begin
          if (freq != '0) conv_phase <= 1'b1;
        end
        fism_pkg::CMD_DIV_LAT: begin
          if (freq != '0) conv_phase <= 1'b1;
          delta <= lat_delta;
        end
        fism_pkg::CMD_ACC_FRAME: begin
          frame_sum <= sat_add(frame_sum, us);
          if (us > frame_peak) frame_peak <= us;
          frame_tally <= sat_inc(frame_tally);
        end
        fism_pkg::CMD_ACC_LAT: begin
          rep_poll_tick <= poll_tick;
          lat_sum <= sat_add(lat_sum, us);
          if (us > lat_peak) lat_peak <= us;
          lat_tally <= sat_inc(lat_tally);
        end
        fism_pkg::CMD_TALLY: begin
          present_tally <= sat_inc(present_tally);
          if (item.present_failed) failure_tally <= sat_inc(failure_tally);
          due <= (item.ms_now - last_ms) >= interval;
        end
        fism_pkg::CMD_EMIT: begin
          last_ms <= item.ms_now;
          frame_sum <= '0; frame_peak <= '0; lat_sum <= '0; lat_peak <= '0;
          frame_tally <= '0; present_tally <= '0; failure_tally <= '0;
          lat_tally <= '0;
        end
        default: ;
      endcase
    end
  end

  // Latch whole part after first conversion pass.
  always_ff @(posedge clk) begin
    if (cmd == fism_pkg::CMD_DIV_FRAME || cmd == fism_pkg::CMD_DIV_LAT) whole <= '0;
    if (conv_phase && !div_busy) whole <= div_q[62:0];
  end

  // Results captured as the divider finishes each average stage.
  always_ff @(posedge clk) begin
    if (cmd == fism_pkg::CMD_DIV_LAVG) begin
      favg <= frame_tally != '0 ? div_q[62:0] : '0;
      result.interval_mean_us <= frame_tally != '0 ? div_q[62:0] : '0;
      result.present_count <= present_tally;
      result.failure_count <= failure_tally;
      result.interval_count <= frame_tally;
      result.interval_peak_us <= frame_peak;
      result.latency_samples <= lat_tally;
      result.latency_max_us <= lat_peak;
    end
    if (cmd == fism_pkg::CMD_DIV_RATE)
      result.latency_avg_us <= lat_tally != '0 ? div_q[62:0] : '0;
    if (cmd == fism_pkg::CMD_EMIT)
      result.rate_millihertz <= favg != '0 ? div_q[29:0] : '0;
  end
endmodule

/* src/fism_ctrl.sv */
// Controller: sequences one item through the datapath.
module fism_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fism_pkg::status_t status,
  output fism_pkg::cmd_t    cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIVF, S_WAITF, S_ACCF, S_DIVL, S_WAITL, S_ACCL,
    S_TALLY, S_DECIDE, S_FAVG, S_WFAVG, S_LAVG, S_WLAVG, S_RATE, S_WRATE,
    S_EMIT, S_HOLD
  } state_t;
  state_t state;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = fism_pkg::CMD_NONE;
    unique case (state)
      S_IDLE:  if (in_valid) cmd = fism_pkg::CMD_LOAD;
      S_DIVF:  cmd = fism_pkg::CMD_DIV_FRAME;
      S_ACCF:  cmd = fism_pkg::CMD_ACC_FRAME;
      S_DIVL:  cmd = fism_pkg::CMD_DIV_LAT;
      S_ACCL:  cmd = fism_pkg::CMD_ACC_LAT;
      S_TALLY: cmd = fism_pkg::CMD_TALLY;
      S_FAVG:  cmd = fism_pkg::CMD_DIV_FAVG;
      S_LAVG:  cmd = fism_pkg::CMD_DIV_LAVG;
      S_RATE:  cmd = fism_pkg::CMD_DIV_RATE;
      S_EMIT:  cmd = fism_pkg::CMD_EMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          if (!status.is_present) state <= S_IDLE;
          else if (status.frame_ok) state <= S_DIVF;
          else if (status.lat_ok) state <= S_DIVL;
          else state <= S_TALLY;
        end
        S_DIVF:  state <= S_WAITF;
        S_WAITF: if (!status.div_busy) state <= S_ACCF;
        S_ACCF:  state <= status.lat_ok ? S_DIVL : S_TALLY;
        S_DIVL:  state <= S_WAITL;
        S_WAITL: if (!status.div_busy) state <= S_ACCL;
        S_ACCL:  state <= S_TALLY;
        S_TALLY: state <= S_DECIDE;
        S_DECIDE: state <= status.report_due ? S_FAVG : S_IDLE;
        S_FAVG:  state <= S_WFAVG;
        S_WFAVG: if (!status.div_busy) state <= S_LAVG;
        S_LAVG:  state <= S_WLAVG;
        S_WLAVG: if (!status.div_busy) state <= S_RATE;
        S_RATE:  state <= S_WRATE;
        S_WRATE: if (!status.div_busy) state <= S_EMIT;
        S_EMIT: begin
          state <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD:  if (out_ready) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/frame_interval_statistics_monitor.sv */
// Top level of the frame interval statistics monitor.
//   channel | dir | payload
//   in      | in  | opcode, counter_tick, ms_now, present_failed
//   out     | out | counts, averages, maxima, rate_millihertz
//   cfg     | in  | index, data (0 counter_frequency, 1 report_interval_ms)
// A poll, display reset or unused opcode goes from the check state back to idle. A
// present runs the tally and decide states plus, for each tick conversion it needs
// (frame interval, poll latency), two passes of the shared divider. A due report adds
// three divisions and holds until taken. Reset is synchronous; no clearing pass.
module frame_interval_statistics_monitor (
  input logic clk,
  input logic rst,
  fism_if.sink   in,
  fism_if.source out,
  fism_if.sink   cfg
);
  fism_pkg::status_t   status;
  fism_pkg::cmd_t      cmd;
  fism_pkg::in_item_t  in_item;
  fism_pkg::out_item_t result;
  fism_pkg::cfg_item_t cfg_item;
  logic cfg_we;

  assign in_item = fism_pkg::in_item_t'(in.data);
  assign cfg_item = fism_pkg::cfg_item_t'(cfg.data);
  assign cfg.ready = 1'b1;
  assign cfg_we = cfg.valid;
  assign out.data = result;

  fism_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .status(status), .cmd(cmd)
  );

  fism_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_item), .cfg(cfg_item),
    .cfg_we(cfg_we), .status(status), .result(result)
  );
endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the frame interval statistics monitor.
module tb;

  localparam logic [63:0] SAT63 = {1'b0, {63{1'b1}}};
  localparam logic [30:0] SAT31 = {31{1'b1}};
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  fism_if #(.W($bits(fism_pkg::in_item_t)))  in_ch ();
  fism_if #(.W($bits(fism_pkg::out_item_t))) out_ch ();
  fism_if #(.W($bits(fism_pkg::cfg_item_t))) cfg_ch ();

  frame_interval_statistics_monitor uut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch),
    .cfg(cfg_ch)
  );

  logic [31:0] freq_reg;
  logic [31:0] interval_reg;
  logic [63:0] prev_tick;
  logic [63:0] poll_at;
  logic [63:0] counted_poll;
  logic [63:0] frame_sum;
  logic [63:0] frame_peak;
  logic [63:0] lat_sum;
  logic [63:0] lat_peak;
  logic [30:0] frame_cnt;
  logic [30:0] present_cnt;
  logic [30:0] fail_cnt;
  logic [30:0] lat_cnt;
  logic [31:0] last_report;

  fism_pkg::out_item_t pending_reports[$];
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  bit calm = 1'b0;

  logic [62:0] tick_now;
  logic [31:0] ms_clock;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    if (a > SAT63 || b > SAT63 - a) return SAT63;
    return a + b;
  endfunction

  function automatic logic [30:0] sat_inc(logic [30:0] v);
    return (v == SAT31) ? SAT31 : v + 31'd1;
  endfunction

  function automatic logic [63:0] ticks_to_us(logic [63:0] t);
    logic [63:0] f;
    logic [63:0] whole;
    logic [63:0] frac;
    f = {32'd0, freq_reg};
    if (t == 64'd0 || f == 64'd0) return 64'd0;
    whole = t / f;
    frac = (t % f) * 64'd1000000 / f;
    if (whole > SAT63 / 64'd1000000) return SAT63;
    return sat_add(whole * 64'd1000000, frac);
  endfunction

  function automatic void clear_period();
    frame_sum = 0;
    frame_peak = 0;
    lat_sum = 0;
    lat_peak = 0;
    frame_cnt = 0;
    present_cnt = 0;
    fail_cnt = 0;
    lat_cnt = 0;
  endfunction

  function automatic void reset_stats();
    freq_reg = 32'd10000000;
    interval_reg = 32'd5000;
    prev_tick = 0;
    poll_at = 0;
    counted_poll = 0;
    last_report = 0;
    clear_period();
  endfunction

  function automatic void account_event(fism_pkg::in_item_t it);
    logic [63:0] tick;
    logic [63:0] prev;
    logic [63:0] us;
    logic [63:0] favg;
    logic [63:0] lavg;
    logic [31:0] elapsed;
    fism_pkg::out_item_t r;
    tick = {1'b0, it.counter_tick};
    if (it.opcode == fism_pkg::OP_POLL) begin
      poll_at = tick;
      return;
    end
    if (it.opcode == fism_pkg::OP_DRESET) begin
      prev_tick = 0;
      return;
    end
    if (it.opcode != fism_pkg::OP_PRESENT) return;
    prev = prev_tick;
    prev_tick = tick;
    if (prev != 0) begin
      us = (tick > prev) ? ticks_to_us(tick - prev) : 64'd0;
      frame_sum = sat_add(frame_sum, us);
      if (us > frame_peak) frame_peak = us;
      frame_cnt = sat_inc(frame_cnt);
    end
    if (poll_at != 0 && poll_at != counted_poll && tick >= poll_at) begin
      counted_poll = poll_at;
      us = ticks_to_us(tick - poll_at);
      lat_sum = sat_add(lat_sum, us);
      if (us > lat_peak) lat_peak = us;
      lat_cnt = sat_inc(lat_cnt);
    end
    present_cnt = sat_inc(present_cnt);
    if (it.present_failed) fail_cnt = sat_inc(fail_cnt);
    elapsed = it.ms_now - last_report;
    if (elapsed < interval_reg) return;
    last_report = it.ms_now;
    favg = (frame_cnt != 0) ? frame_sum / {33'd0, frame_cnt} : 64'd0;
    lavg = (lat_cnt != 0) ? lat_sum / {33'd0, lat_cnt} : 64'd0;
    r.present_count = present_cnt;
    r.failure_count = fail_cnt;
    r.interval_count = frame_cnt;
    r.interval_mean_us = favg[62:0];
    r.interval_peak_us = frame_peak[62:0];
    r.rate_millihertz = (favg != 0) ? 30'(64'd1000000000 / favg) : 30'd0;
    r.latency_samples = lat_cnt;
    r.latency_avg_us = lavg[62:0];
    r.latency_max_us = lat_peak[62:0];
    pending_reports.push_back(r);
    clear_period();
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("frame_interval_statistics_monitor regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    fism_pkg::out_item_t got;
    fism_pkg::out_item_t want;
    got = out_ch.data;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report: %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got.present_count !== want.present_count
            || got.failure_count !== want.failure_count
            || got.interval_count !== want.interval_count
            || got.interval_mean_us !== want.interval_mean_us
            || got.interval_peak_us !== want.interval_peak_us
            || got.rate_millihertz !== want.rate_millihertz
            || got.latency_samples !== want.latency_samples
            || got.latency_avg_us !== want.latency_avg_us
            || got.latency_max_us !== want.latency_max_us) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report mismatch\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [62:0] tick, logic [31:0] ms, bit failed);
    fism_pkg::in_item_t it;
    it.opcode = op;
    it.counter_tick = tick;
    it.ms_now = ms;
    it.present_failed = failed;
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    account_event(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    fism_pkg::cfg_item_t c;
    c.index = idx;
    c.data = value;
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == fism_pkg::REG_FREQ) freq_reg = value;
    else interval_reg = value;
  endtask

  task automatic test_directed_defaults();
    send_item(fism_pkg::OP_PRESENT, 63'd0, 32'd0, 1'b0);
    send_item(fism_pkg::OP_POLL, 63'd1000, 32'hFFFFFFFF, 1'b1);
    send_item(fism_pkg::OP_PRESENT, 63'd20000, 32'd100, 1'b1);
    send_item(fism_pkg::OP_PRESENT, 63'd186667, 32'd5100, 1'b0);
    send_item(fism_pkg::OP_PRESENT, 63'd100000, 32'd5101, 1'b0);
    send_item(fism_pkg::OP_POLL, 63'd500000, 32'd0, 1'b0);
    send_item(fism_pkg::OP_PRESENT, 63'd400000, 32'd5102, 1'b0);
    send_item(fism_pkg::OP_UNUSED, {31'h7FFFFFFF, 32'hFFFFFFFF}, 32'hFFFFFFFF, 1'b1);
    send_item(fism_pkg::OP_DRESET, 63'h2A, 32'h5555, 1'b1);
    send_item(fism_pkg::OP_PRESENT, {63{1'b1}}, 32'hFFFFFFFF, 1'b1);
    send_item(fism_pkg::OP_PRESENT, {63{1'b1}}, 32'd3, 1'b0);
  endtask

  task automatic test_directed_extremes();
    write_reg(fism_pkg::REG_FREQ, 32'd0);
    write_reg(fism_pkg::REG_INTERVAL, 32'd0);
    send_item(fism_pkg::OP_POLL, 63'd10, 32'd0, 1'b0);
    send_item(fism_pkg::OP_PRESENT, 63'd50, 32'd7, 1'b0);
    send_item(fism_pkg::OP_PRESENT, 63'd90, 32'd7, 1'b1);
    write_reg(fism_pkg::REG_FREQ, 32'hFFFFFFFF);
    send_item(fism_pkg::OP_PRESENT, 63'h7FFFFFFF_00000000, 32'd8, 1'b0);
    send_item(fism_pkg::OP_PRESENT, {63{1'b1}}, 32'd9, 1'b0);
    write_reg(fism_pkg::REG_FREQ, 32'd1);
    send_item(fism_pkg::OP_DRESET, 63'd0, 32'd0, 1'b0);
    send_item(fism_pkg::OP_POLL, 63'd1, 32'd0, 1'b0);
    send_item(fism_pkg::OP_PRESENT, 63'd1, 32'd10, 1'b0);
    send_item(fism_pkg::OP_PRESENT, {63{1'b1}}, 32'd11, 1'b1);
    write_reg(fism_pkg::REG_INTERVAL, 32'd1000);
    send_item(fism_pkg::OP_DRESET, 63'd0, 32'd0, 1'b0);
    send_item(fism_pkg::OP_PRESENT, 63'd5, 32'd20, 1'b0);
    send_item(fism_pkg::OP_PRESENT, 63'h4000000000000000, 32'd30, 1'b0);
    send_item(fism_pkg::OP_PRESENT, {63{1'b1}}, 32'd2000, 1'b0);
  endtask

  task automatic run_traffic(int n, logic [63:0] tick_span, int unsigned ms_span);
    int unsigned pick;
    logic [63:0] step;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      step = {$urandom, $urandom} % (tick_span + 64'd1);
      if (pick < 70) begin
        tick_now = tick_now + step[62:0] + 63'd1;
        ms_clock = ms_clock + $urandom_range(ms_span);
        send_item(fism_pkg::OP_PRESENT, tick_now, ms_clock, 1'($urandom_range(1)));
      end else if (pick < 85) begin
        send_item(fism_pkg::OP_POLL, tick_now + (step[62:0] >> $urandom_range(4)),
                  $urandom, 1'($urandom_range(1)));
      end else if (pick < 90) begin
        send_item(fism_pkg::OP_DRESET, 63'({$urandom, $urandom}), $urandom,
                  1'($urandom_range(1)));
      end else if (pick < 94) begin
        send_item(fism_pkg::OP_UNUSED, 63'({$urandom, $urandom}), $urandom,
                  1'($urandom_range(1)));
      end else begin
        send_item(fism_pkg::OP_PRESENT,
                  ($urandom_range(3) == 0) ? 63'd0 : 63'({$urandom, $urandom}),
                  $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_default_rate();
    write_reg(fism_pkg::REG_FREQ, 32'd10000000);
    write_reg(fism_pkg::REG_INTERVAL, 32'd5000);
    calm = 1'b1;
    run_traffic(150, 64'd400000, 1500);
    calm = 1'b0;
    run_traffic(250, 64'd400000, 1500);
  endtask

  task automatic test_random_settings();
    write_reg(fism_pkg::REG_FREQ, $urandom);
    write_reg(fism_pkg::REG_INTERVAL, $urandom_range(3000));
    run_traffic(300, 64'hFFFFFFFF, 1000);
  endtask

  task automatic test_every_present_reports();
    write_reg(fism_pkg::REG_FREQ, 32'd1000);
    write_reg(fism_pkg::REG_INTERVAL, 32'd0);
    run_traffic(200, 64'd5000, 3);
  endtask

  task automatic test_top_settings();
    write_reg(fism_pkg::REG_FREQ, 32'hFFFFFFFF);
    write_reg(fism_pkg::REG_INTERVAL, 32'hFFFFFFFF);
    run_traffic(100, 64'hFFFFFFFFFF, 100);
    send_item(fism_pkg::OP_PRESENT, tick_now + 63'd1, last_report - 32'd1, 1'b0);
  endtask

  task automatic test_saturating_sums();
    write_reg(fism_pkg::REG_FREQ, 32'd1);
    write_reg(fism_pkg::REG_INTERVAL, 32'd100);
    run_traffic(250, 64'h3FFFFFFFFFFFFFFF, 60);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    tick_now = 63'd1;
    ms_clock = 32'd0;
    reset_stats();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_directed_extremes();
    test_default_rate();
    test_random_settings();
    test_every_present_reports();
    test_top_settings();
    test_saturating_sums();
    drain();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("frame_interval_statistics_monitor regression: pass");
    end else begin
      $display("frame_interval_statistics_monitor regression: fail");
    end
    $finish;
  end
endmodule
